/* hdl/sha256_stream_hasher_core_defines.svh */
// assertion helpers used by the hasher core rtl
`ifndef SHA256_STREAM_HASHER_CORE_DEFINES_SVH
`define SHA256_STREAM_HASHER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SHS_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("sha256 core: same-cycle check failed");

// next-cycle implication, checked outside reset
`define SHS_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("sha256 core: next-cycle check failed");

`endif

/* hdl/sha256_pkg.sv */
package sha256_pkg;

	typedef logic [7:0][31:0] word_vec_t;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_ROUND = 5'b00010,
		ST_FOLD  = 5'b00100,
		ST_PAD   = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

	typedef struct packed {
		logic       load;
		logic [7:0] data;
		logic       step;
	} sched_ctl_t;

	typedef struct packed {
		logic init;
		logic step;
	} rnd_ctl_t;

	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [6:0] LEN_POS  = 7'd56;

	localparam word_vec_t IV = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	localparam logic [31:0] RC [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
	endfunction

endpackage

/* hdl/sha256_sched.sv */
module sha256_sched (
	input  logic                   clk,
	input  sha256_pkg::sched_ctl_t ctl,
	output logic [31:0]            w_cur
);
	import sha256_pkg::*;

	// 16-word window, doubles as the byte-wide block buffer
	logic [31:0] win_q [16];
	logic [31:0] w_next;

	assign w_next = small_sigma1(win_q[14]) + win_q[9] + small_sigma0(win_q[1]) + win_q[0];
	assign w_cur  = win_q[0];

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= {win_q[i][23:0], win_q[i+1][31:24]};
			end
			win_q[15] <= {win_q[15][23:0], ctl.data};
		end else if (ctl.step) begin
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[15] <= w_next;
		end
	end

endmodule

/* hdl/sha256_round.sv */
module sha256_round (
	input  logic                  clk,
	input  sha256_pkg::rnd_ctl_t  ctl,
	input  sha256_pkg::word_vec_t init_words,
	input  logic [31:0]           k_t,
	input  logic [31:0]           w_t,
	output sha256_pkg::word_vec_t work
);
	import sha256_pkg::*;

	// working variables a..h at index 0..7
	word_vec_t   work_q;
	logic [31:0] ch, maj, t1, t2;

	assign ch  = (work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]);
	assign maj = (work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]);
	assign t1  = work_q[7] + big_sigma1(work_q[4]) + ch + k_t + w_t;
	assign t2  = big_sigma0(work_q[0]) + maj;
	assign work = work_q;

	always_ff @(posedge clk) begin
		if (ctl.init) begin
			work_q <= init_words;
		end else if (ctl.step) begin
			work_q[7] <= work_q[6];
			work_q[6] <= work_q[5];
			work_q[5] <= work_q[4];
			work_q[4] <= work_q[3] + t1;
			work_q[3] <= work_q[2];
			work_q[2] <= work_q[1];
			work_q[1] <= work_q[0];
			work_q[0] <= t1 + t2;
		end
	end

endmodule

/* hdl/sha256_stream_hasher_core.sv */
// sha-256 over a byte stream, one message after another
// input channel (in_valid/in_ready): each item carries message_byte when
// byte_present is high; end_of_message closes the message after that byte,
// and an item with no byte and no end mark changes nothing
// output channel (out_valid/out_ready): eight items per message, the digest
// words in order, word_number 0..7, final_word high on the last one
// flow: a byte item is taken whenever in_ready is high; the 64th byte of a block starts
// the compression, the rounds on the single shared round unit and then the
// fold into the chaining words, during which in_ready stays low
// end of message: padding shifts one byte a cycle into the block window
// until the block is full, then it is compressed; when the length does not
// fit (fill count 56 or more), a second block is padded and compressed
// the digest then waits in the chaining registers; a stalled receiver just
// holds the current word, nothing else advances and in_ready stays low
// after word 7 is taken the core reloads the initial hash values
// reset: asynchronous, clears the sequencer, fill count, bit length and
// loads the initial hash values; block buffer content is not cleared
`include "sha256_stream_hasher_core_defines.svh"

module sha256_stream_hasher_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  message_byte,
	input  logic        byte_present,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_number,
	output logic        final_word
);
	import sha256_pkg::*;

	state_t      state_q;
	logic [6:0]  fill_q;        // bytes in the current block, 64 while compressing
	logic [63:0] bits_q;        // message length in bits, shifted out during padding
	logic [5:0]  round_q;
	logic [2:0]  word_q;
	logic        end_pend_q;    // message end seen, digest not yet ready
	logic        mark_done_q;   // 0x80 marker already in the window
	logic        len_blk_q;     // length field goes into this block
	logic        final_q;       // block under compression is the last one
	word_vec_t   chain_q;

	sched_ctl_t  sctl;
	rnd_ctl_t    rctl;
	logic [31:0] w_t;
	word_vec_t   work;
	logic        acc_in;
	logic        full_in;
	logic        pad_last;
	logic        len_byte;
	logic [7:0]  pad_byte;

	assign in_ready = (state_q == ST_IDLE);
	assign acc_in   = in_valid && in_ready;
	// 64th byte of a block arrives
	assign full_in  = acc_in && byte_present && (fill_q[5:0] == 6'd63);
	assign pad_last = (state_q == ST_PAD) && (fill_q == 7'd63);
	assign len_byte = mark_done_q && len_blk_q && (fill_q >= LEN_POS);

	// padding byte: marker first, then zeros, then the length big-endian
	always_comb begin
		if (!mark_done_q) begin
			pad_byte = PAD_MARK;
		end else if (len_byte) begin
			pad_byte = bits_q[63:56];
		end else begin
			pad_byte = 8'h00;
		end
	end

	always_comb begin
		sctl.load = (acc_in && byte_present) || (state_q == ST_PAD);
		sctl.data = (state_q == ST_PAD) ? pad_byte : message_byte;
		sctl.step = (state_q == ST_ROUND);
		rctl.init = full_in || pad_last;
		rctl.step = (state_q == ST_ROUND);
	end

	sha256_sched u_sched (
		.clk   (clk),
		.ctl   (sctl),
		.w_cur (w_t)
	);

	sha256_round u_round (
		.clk        (clk),
		.ctl        (rctl),
		.init_words (chain_q),
		.k_t        (RC[round_q]),
		.w_t        (w_t),
		.work       (work)
	);

	// output straight from the chaining registers, held while stalled
	assign out_valid   = (state_q == ST_EMIT);
	assign digest_word = chain_q[word_q];
	assign word_number = word_q;
	assign final_word  = (word_q == 3'd7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			bits_q      <= '0;
			round_q     <= '0;
			word_q      <= '0;
			end_pend_q  <= 1'b0;
			mark_done_q <= 1'b0;
			len_blk_q   <= 1'b0;
			final_q     <= 1'b0;
			chain_q     <= IV;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (acc_in) begin
						if (byte_present) begin
							fill_q <= fill_q + 7'd1;
							bits_q <= bits_q + 64'd8;
						end
						if (full_in) begin
							state_q     <= ST_ROUND;
							round_q     <= '0;
							final_q     <= 1'b0;
							end_pend_q  <= end_of_message;
							mark_done_q <= 1'b0;
						end else if (end_of_message) begin
							state_q     <= ST_PAD;
							end_pend_q  <= 1'b1;
							mark_done_q <= 1'b0;
						end
					end
				end
				ST_ROUND: begin
					round_q <= round_q + 6'd1;
					if (round_q == 6'd63) begin
						state_q <= ST_FOLD;
					end
				end
				ST_FOLD: begin
					for (int i = 0; i < 8; i++) begin
						chain_q[i] <= chain_q[i] + work[i];
					end
					fill_q <= '0;
					if (final_q) begin
						state_q <= ST_EMIT;
						word_q  <= '0;
					end else if (end_pend_q) begin
						state_q <= ST_PAD;
						// spill block done, length lands in the next one
						if (mark_done_q) begin
							len_blk_q <= 1'b1;
						end
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_PAD: begin
					fill_q <= fill_q + 7'd1;
					if (!mark_done_q) begin
						mark_done_q <= 1'b1;
						len_blk_q   <= (fill_q < LEN_POS);
					end
					if (len_byte) begin
						bits_q <= {bits_q[55:0], 8'h00};
					end
					if (pad_last) begin
						state_q <= ST_ROUND;
						round_q <= '0;
						final_q <= mark_done_q && len_blk_q;
					end
				end
				ST_EMIT: begin
					if (out_ready) begin
						word_q <= word_q + 3'd1;
						if (word_q == 3'd7) begin
							state_q     <= ST_IDLE;
							chain_q     <= IV;
							fill_q      <= '0;
							bits_q      <= '0;
							end_pend_q  <= 1'b0;
							mark_done_q <= 1'b0;
							len_blk_q   <= 1'b0;
							final_q     <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// never offering a digest word while taking input
	`SHS_ASSERT_IMP(a_no_overlap, clk, arst_n, out_valid, !in_ready)
	// fill count only reaches 64 as a full block, never beyond
	`SHS_ASSERT_IMP(a_fill_range, clk, arst_n, fill_q[6], fill_q[5:0] == 6'd0)
	// last round hands over to the fold step
	`SHS_ASSERT_NXT(a_round_end, clk, arst_n,
		(state_q == ST_ROUND) && (round_q == 6'd63), state_q == ST_FOLD)
	// after the last digest word the core is empty again
	`SHS_ASSERT_NXT(a_msg_restart, clk, arst_n, out_valid && out_ready && final_word,
		in_ready && (fill_q == 7'd0) && (bits_q == 64'd0))

endmodule

/* verif/digest_checker.sv */
// watches both channels of the hasher, keeps its own sha-256 state and
// compares every digest word against the oldest predicted one
module digest_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [7:0]        message_byte,
	input  logic              byte_present,
	input  logic              end_of_message,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [31:0]       digest_word,
	input  logic [2:0]        word_number,
	input  logic              final_word,
	output int unsigned       mismatches,
	output int unsigned       words_owed
);

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        last;
	} digest_entry_t;

	localparam logic [0:63][31:0] ROUND_K = {
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [0:7][31:0] H_INIT = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [7:0] PAD_BYTE   = 8'h80;
	localparam int         LEN_OFFSET = 56;

	logic [7:0]    blk [64];
	int unsigned   fill;
	logic [63:0]   bit_len;
	logic [31:0]   hash [8];
	digest_entry_t digest_q [$];
	int unsigned   err_cnt = 0;

	function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	task automatic restart_message();
		fill = 0;
		bit_len = '0;
		for (int j = 0; j < 8; j++)
			hash[j] = H_INIT[j];
	endtask

	task automatic compress_block();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] s0, s1, t1, t2;
		for (int t = 0; t < 16; t++)
			w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
		for (int t = 16; t < 64; t++) begin
			s0 = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
			s1 = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
			w[t] = s1 + w[t-7] + s0 + w[t-16];
		end
		for (int j = 0; j < 8; j++)
			v[j] = hash[j];
		for (int t = 0; t < 64; t++) begin
			t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + w[t];
			t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int j = 0; j < 8; j++)
			hash[j] = hash[j] + v[j];
	endtask

	// pad, append the bit length, compress and queue the eight words
	task automatic finish_message();
		int pos;
		digest_entry_t e;
		pos = fill;
		blk[pos] = PAD_BYTE;
		pos++;
		if (pos > LEN_OFFSET) begin
			while (pos < 64) begin
				blk[pos] = 8'h00;
				pos++;
			end
			compress_block();
			pos = 0;
		end
		while (pos < LEN_OFFSET) begin
			blk[pos] = 8'h00;
			pos++;
		end
		for (int j = 0; j < 8; j++)
			blk[LEN_OFFSET + j] = bit_len[63 - 8*j -: 8];
		compress_block();
		for (int j = 0; j < 8; j++) begin
			e.word = hash[j];
			e.idx  = 3'(j);
			e.last = (j == 7);
			digest_q.push_back(e);
		end
		restart_message();
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < 64; j++)
				blk[j] = 8'h00;
			restart_message();
			digest_q.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (digest_q.size() == 0) begin
					$error("digest word %h with nothing expected", digest_word);
					err_cnt++;
				end else begin
					if (digest_word !== digest_q[0].word) begin
						$error("digest_word: expected %h, got %h", digest_q[0].word, digest_word);
						err_cnt++;
					end
					if (word_number !== digest_q[0].idx) begin
						$error("word_number: expected %0d, got %0d", digest_q[0].idx, word_number);
						err_cnt++;
					end
					if (final_word !== digest_q[0].last) begin
						$error("final_word: expected %b, got %b", digest_q[0].last, final_word);
						err_cnt++;
					end
					void'(digest_q.pop_front());
				end
			end
			if (in_valid && in_ready) begin
				if (byte_present) begin
					blk[fill] = message_byte;
					fill++;
					bit_len = bit_len + 64'd8;
					if (fill == 64) begin
						compress_block();
						fill = 0;
					end
				end
				if (end_of_message)
					finish_message();
			end
		end
		mismatches <= err_cnt;
		words_owed <= digest_q.size();
	end

endmodule

/* verif/tb_top.sv */
// stimulus and verdict for the stream hasher; all checking lives in the
// digest checker instantiated next to the block
module tb_top;

	localparam int PHASE_ITEMS = 100;   // counted items per pressure phase
	localparam int NOISE_PCT   = 10;    // chance of an empty item before a byte
	localparam int TAIL_CYCLES = 300;   // quiet time after the last digest word

	logic        clk;
	logic        arst_n         = 1'b0;
	logic        in_valid       = 1'b0;
	logic        in_ready;
	logic [7:0]  message_byte   = 8'h00;
	logic        byte_present   = 1'b0;
	logic        end_of_message = 1'b0;
	logic        out_valid;
	logic        out_ready      = 1'b0;
	logic [31:0] digest_word;
	logic [2:0]  word_number;
	logic        final_word;

	int unsigned mismatches;
	int unsigned words_owed;

	// idle and stall odds in percent, changed per phase
	int idle_pct  = 0;
	int stall_pct = 0;

	int items_sent = 0;   // items with a byte or an end mark
	int messages   = 0;
	int longest    = 0;

	sha256_stream_hasher_core DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.message_byte   (message_byte),
		.byte_present   (byte_present),
		.end_of_message (end_of_message),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.digest_word    (digest_word),
		.word_number    (word_number),
		.final_word     (final_word)
	);

	digest_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.message_byte   (message_byte),
		.byte_present   (byte_present),
		.end_of_message (end_of_message),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.digest_word    (digest_word),
		.word_number    (word_number),
		.final_word     (final_word),
		.mismatches     (mismatches),
		.words_owed     (words_owed)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver side: random back-pressure, redrawn every cycle
	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= stall_pct);

	// one item on the input channel; returns at the edge that accepts it,
	// so the next call can keep valid high without a drop
	task automatic send_item(input logic [7:0] b, input logic present, input logic eom);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		message_byte   <= b;
		byte_present   <= present;
		end_of_message <= eom;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (present || eom)
			items_sent++;
		if (eom)
			messages++;
	endtask

	// a whole message of random bytes; the end mark either rides on the
	// last byte or comes as a separate empty end item
	task automatic send_message(input int len, input bit split_end);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(99) < NOISE_PCT)
				send_item(8'($urandom_range(255)), 1'b0, 1'b0);
			send_item(8'($urandom_range(255)), 1'b1, (i == len - 1) && !split_end);
		end
		if (len == 0 || split_end)
			send_item(8'($urandom_range(255)), 1'b0, 1'b1);
		if (len > longest)
			longest = len;
	endtask

	// mostly short messages, with weight on the padding boundaries:
	// 55/56/57 decide whether the length fits, 63/64/65 straddle a full
	// block, 119..128 repeat the length boundary a block later and reach 128
	function automatic int pick_length();
		case ($urandom_range(15))
			0:        return 0;
			10:       return $urandom_range(60, 21);
			11:       return $urandom_range(57, 55);
			12:       return $urandom_range(65, 63);
			13:       return $urandom_range(128, 119);
			14, 15:   return $urandom_range(4, 1);
			default:  return $urandom_range(20, 1);
		endcase
	endfunction

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty message straight after reset
		send_item(8'h00, 1'b0, 1'b1);
		// an item with neither byte nor end mark changes nothing
		send_item(8'hff, 1'b0, 1'b0);
		// single extreme bytes that also close the message
		send_item(8'h00, 1'b1, 1'b1);
		send_item(8'hff, 1'b1, 1'b1);
		// "abc", end mark on the last byte
		send_item(8'h61, 1'b1, 1'b0);
		send_item(8'h62, 1'b1, 1'b0);
		send_item(8'h63, 1'b1, 1'b1);
		// bytes then an empty end item
		send_item(8'haa, 1'b1, 1'b0);
		send_item(8'h55, 1'b0, 1'b0);
		send_item(8'h55, 1'b1, 1'b0);
		send_item(8'h00, 1'b0, 1'b1);
		// empty message right after a digest
		send_item(8'h80, 1'b0, 1'b1);

		// random messages under four pressure phases: free running,
		// sparse sender, slow receiver, both moderately throttled
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 80; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 80; end
				default: begin idle_pct = 36; stall_pct = 36; end
			endcase
			while (items_sent < PHASE_ITEMS * (ph + 1))
				send_message(pick_length(), $urandom_range(3) == 0);
		end
		in_valid <= 1'b0;

		// let the checker's count settle past the last accepted item
		@(posedge clk);
		while (words_owed != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("hashed %0d messages from %0d items, up to %0d bytes long",
			messages, items_sent, longest);
		$display("covered empty and split-end messages, both padding cases, sender gaps and receiver stalls");
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#3000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
